>>> design/sepa_pkg.sv
// sepa_pkg: field widths, payload types and the accumulator entry type
// for the shift EMA point averager. No dependencies.
package sepa_pkg;

    localparam int STEP_W  = 3;
    localparam int POINT_W = 8;
    localparam int X_W     = 16;
    localparam int Y_W     = 8;
    localparam int ACC_X_W = 32;
    localparam int ACC_Y_W = 16;
    localparam int SHIFT_W = 4;

    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [POINT_W-1:0] point_t;
    typedef logic [X_W-1:0]     x_t;
    typedef logic [Y_W-1:0]     y_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    // One accumulator entry: both channels of one step and point
    typedef struct packed {
        logic [ACC_X_W-1:0] x;
        logic [ACC_Y_W-1:0] y;
    } acc_t;

endpackage

>>> design/sepa_if.sv
// sepa_if: valid/ready channel interfaces for sample items and averaged items.
// Depends on sepa_pkg.
interface sepa_in_if;
    import sepa_pkg::*;

    logic   valid;
    logic   ready;
    step_t  step;
    point_t point_index;
    x_t     sample_x;
    y_t     sample_y;

    modport source (output valid, output step, output point_index,
                    output sample_x, output sample_y, input ready);
    modport sink   (input valid, input step, input point_index,
                    input sample_x, input sample_y, output ready);
endinterface

interface sepa_out_if;
    import sepa_pkg::*;

    logic valid;
    logic ready;
    x_t   avg_x;
    y_t   avg_y;

    modport source (output valid, output avg_x, output avg_y, input ready);
    modport sink   (input valid, input avg_x, input avg_y, output ready);
endinterface

>>> design/shift_ema_point_averager_unit.sv
// shift_ema_point_averager_unit: top level of the per-point EMA averager.
// Depends on sepa_pkg, sepa_if (sepa_in_if, sepa_out_if) and sepa_update.
//
// Usage:
//   samples  - sink channel; one item per trace point (step, point_index,
//              sample_x, sample_y).
//   averages - source channel; exactly one item (avg_x, avg_y) per sample
//              item, in order.
//   cfg_we / cfg_wdata - write of the averaging shift k. Write only while
//              the block is idle. k = 0 passes samples straight through.
//   Accumulators live in one synchronous memory of NUM_STEPS*NUM_POINTS
//   entries (1280 at default values) with a registered read.
//   Throughput: one item per cycle outside the clearing pass and output
//   stalls, bounded by the single read and single write port of the
//   accumulator memory; a read that hits the entry being written back in
//   the same cycle is forwarded from the update logic.
//   Path: an item goes through the read stage, then the output register.
//   Reset: the accumulator memory is zeroed by a clearing pass over all
//   NUM_STEPS*NUM_POINTS entries, during which samples.ready stays low.
//   Writing a k different from the current one starts the same pass.
//   Stall: the result waits in the output register; one more item can be
//   in the read stage behind it, then samples.ready drops until the
//   receiver takes the waiting item.
module shift_ema_point_averager_unit #(
    parameter int NUM_POINTS = 256,
    parameter int NUM_STEPS  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    sepa_in_if.sink           samples,
    sepa_out_if.source        averages,
    input  logic              cfg_we,
    input  sepa_pkg::shift_t  cfg_wdata
);
    import sepa_pkg::*;

    localparam int DEPTH  = NUM_STEPS * NUM_POINTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [ADDR_W-1:0] addr_t;

    // Accumulator memory
    acc_t  acc_mem [DEPTH];
    acc_t  rd_acc_reg;

    // Configuration and clearing pass
    shift_t shift_reg;
    logic   clr_active_reg;
    addr_t  clr_addr_reg;

    // Read stage (item waits here for memory data)
    logic   s1_valid_reg;
    logic   s1_bypass_reg;
    addr_t  s1_addr_reg;
    x_t     s1_x_reg;
    y_t     s1_y_reg;
    logic   fwd_hit_reg;
    acc_t   fwd_acc_reg;

    // Output register
    logic   out_valid_reg;
    x_t     out_x_reg;
    y_t     out_y_reg;

    logic   in_accept;
    logic   in_bypass;
    addr_t  in_addr;
    logic   out_free;
    logic   s1_advance;
    logic   s1_write;
    acc_t   s1_acc;
    acc_t   upd_acc;
    x_t     upd_x;
    y_t     upd_y;
    logic   mem_we;
    addr_t  mem_waddr;
    acc_t   mem_wdata;
    logic   fwd_hit_next;

    // Bypass on k = 0 or on a step or point outside the store
    assign in_bypass = (shift_reg == '0)
                    || (32'(samples.step) >= 32'(NUM_STEPS))
                    || (32'(samples.point_index) >= 32'(NUM_POINTS));
    assign in_addr   = ADDR_W'(32'(samples.step) * 32'(NUM_POINTS)
                             + 32'(samples.point_index));

    // Output register frees when empty or taken; read stage advances into it
    assign out_free   = !out_valid_reg || averages.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s1_write   = s1_advance && !s1_bypass_reg;

    assign samples.ready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign in_accept     = samples.valid && samples.ready;

    // Forward when the new read collides with this cycle's write-back
    assign fwd_hit_next = s1_write && (s1_addr_reg == in_addr);
    assign s1_acc       = fwd_hit_reg ? fwd_acc_reg : rd_acc_reg;

    sepa_update u_update (
        .shift    (shift_reg),
        .acc      (s1_acc),
        .sample_x (s1_x_reg),
        .sample_y (s1_y_reg),
        .acc_next (upd_acc),
        .avg_x    (upd_x),
        .avg_y    (upd_y)
    );

    // Clearing pass owns the write port; otherwise write back the update
    always_comb
    begin
        mem_we    = clr_active_reg || s1_write;
        mem_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
        mem_wdata = clr_active_reg ? '0 : upd_acc;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept && !in_bypass)
        begin
            rd_acc_reg <= acc_mem[in_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Restart the clearing pass on a changed k; otherwise advance it
            if (cfg_we && (cfg_wdata != shift_reg))
            begin
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end
            else if (clr_active_reg)
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                shift_reg <= cfg_wdata;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (averages.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the read stage: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bypass_reg <= in_bypass;
            s1_addr_reg   <= in_addr;
            s1_x_reg      <= samples.sample_x;
            s1_y_reg      <= samples.sample_y;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_acc_reg   <= upd_acc;
        end
    end

    // Payload of the output register: pass samples through on bypass
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_x_reg <= s1_bypass_reg ? s1_x_reg : upd_x;
            out_y_reg <= s1_bypass_reg ? s1_y_reg : upd_y;
        end
    end

    assign averages.valid = out_valid_reg;
    assign averages.avg_x = out_x_reg;
    assign averages.avg_y = out_y_reg;

endmodule

>>> design/sepa_update.sv
// sepa_update: EMA update of one accumulator entry and the shifted outputs.
// Depends on sepa_pkg.
module sepa_update (
    input  sepa_pkg::shift_t shift,
    input  sepa_pkg::acc_t   acc,
    input  sepa_pkg::x_t     sample_x,
    input  sepa_pkg::y_t     sample_y,
    output sepa_pkg::acc_t   acc_next,
    output sepa_pkg::x_t     avg_x,
    output sepa_pkg::y_t     avg_y
);
    import sepa_pkg::*;

    logic [ACC_X_W-1:0] x_shr;
    logic [ACC_Y_W-1:0] y_shr;

    // acc - (acc >> k) + sample, wrapping at the accumulator width
    always_comb
    begin
        acc_next.x = acc.x - (acc.x >> shift) + ACC_X_W'(sample_x);
        acc_next.y = acc.y - (acc.y >> shift) + ACC_Y_W'(sample_y);
        x_shr      = acc_next.x >> shift;
        y_shr      = acc_next.y >> shift;
        avg_x      = x_shr[X_W-1:0];
        avg_y      = y_shr[Y_W-1:0];
    end

endmodule

>>> design/sepa_checker.sv
// sepa_checker: port-level assertions for shift_ema_point_averager_unit,
// attached by bind. Depends on sepa_pkg.
module sepa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input sepa_pkg::x_t  avg_x,
    input sepa_pkg::y_t  avg_y
);
    import sepa_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // Clearing pass holds off items right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("samples accepted during clearing pass");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(avg_x) && $stable(avg_y))
        else $error("stalled result changed");

    // Accepted item passes the read stage into the output when not blocked
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 (out_ready || !out_valid) |=> out_valid)
        else $error("result missing after accepted item");

    // A fresh result traces back to an accepted item that went straight through the read stage
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 2))
        else $error("result without accepted item");

endmodule

bind shift_ema_point_averager_unit sepa_checker u_sepa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (averages.valid),
    .out_ready (averages.ready),
    .avg_x     (averages.avg_x),
    .avg_y     (averages.avg_y)
);

>>> test/shift_ema_point_averager_unit_test.sv
// shift_ema_point_averager_unit_test: self-checking testbench for the per-point
// EMA averager; a scoreboard class predicts every averaged item from the samples.
// Depends on sepa_pkg, sepa_if and shift_ema_point_averager_unit.
module shift_ema_point_averager_unit_test;
    import sepa_pkg::*;

    localparam int NUM_POINTS     = 256;
    localparam int NUM_STEPS      = 5;
    localparam int ACC_DEPTH      = NUM_STEPS * NUM_POINTS;
    // An accepted item passes the read stage and the output register
    localparam int RESULT_LATENCY = 2;
    // Idle cycles tolerated in a row; covers the clearing pass after reset
    // or a shift change plus the longest random gaps
    localparam int IDLE_LIMIT     = 4 * ACC_DEPTH + 1000;

    typedef enum {MIX_SPREAD, MIX_CLUSTER, MIX_HOT} mix_e;

    typedef struct {
        x_t avg_x;
        y_t avg_y;
    } avg_pair_t;

    // Predict the averaged items and compare them with what the block returns
    class ema_scoreboard;
        logic [ACC_X_W-1:0] acc_x [ACC_DEPTH];
        logic [ACC_Y_W-1:0] acc_y [ACC_DEPTH];
        shift_t             shift_k;
        avg_pair_t          pending_avgs [$];
        int                 failures;

        function new();
            shift_k  = '0;
            failures = 0;
            clear_store();
        endfunction

        function void clear_store();
            foreach (acc_x[i]) acc_x[i] = '0;
            foreach (acc_y[i]) acc_y[i] = '0;
        endfunction

        // A different shift wipes the store; the same one keeps it
        function void write_shift(shift_t k);
            if (k != shift_k)
                clear_store();
            shift_k = k;
        endfunction

        function int pending();
            return pending_avgs.size();
        endfunction

        function void note_sample(step_t s, point_t p, x_t sx, y_t sy);
            int                 idx;
            logic [ACC_X_W-1:0] ax;
            logic [ACC_Y_W-1:0] ay;
            avg_pair_t          res;
            if (shift_k == 0 || s >= NUM_STEPS || p >= NUM_POINTS)
            begin
                res.avg_x = sx;
                res.avg_y = sy;
            end
            else
            begin
                idx = int'(s) * NUM_POINTS + int'(p);
                ax  = acc_x[idx];
                ax  = ax - (ax >> shift_k) + ACC_X_W'(sx);
                acc_x[idx] = ax;
                ay  = acc_y[idx];
                ay  = ay - (ay >> shift_k) + ACC_Y_W'(sy);
                acc_y[idx] = ay;
                res.avg_x = x_t'(ax >> shift_k);
                res.avg_y = y_t'(ay >> shift_k);
            end
            pending_avgs.push_back(res);
        endfunction

        function void check_average(x_t ax, y_t ay);
            avg_pair_t want;
            if (pending_avgs.size() == 0)
            begin
                $error("averaged item with no sample waiting: avg_x %0h avg_y %0h", ax, ay);
                failures++;
                return;
            end
            want = pending_avgs.pop_front();
            if (ax !== want.avg_x)
            begin
                $error("avg_x mismatch: expected %0h, actual %0h", want.avg_x, ax);
                failures++;
            end
            if (ay !== want.avg_y)
            begin
                $error("avg_y mismatch: expected %0h, actual %0h", want.avg_y, ay);
                failures++;
            end
        endfunction
    endclass

    bit      clk;
    logic    rst_n;
    logic    cfg_we;
    shift_t  cfg_wdata;

    sepa_in_if  samples_ch ();
    sepa_out_if averages_ch ();

    ema_scoreboard scoreboard = new();

    // Stretches of back-to-back traffic, counted down on each side
    int send_calm;
    int recv_calm;
    int idle_cycles;

    shift_ema_point_averager_unit #(
        .NUM_POINTS (NUM_POINTS),
        .NUM_STEPS  (NUM_STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .averages  (averages_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pick an idle length: mostly none or short, now and then long, and
    // sometimes start a calm stretch with no idling at all
    function automatic int idle_len(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one sample item after a random gap and hold it until accepted.
    // Enter and leave at a falling edge; keep valid high between items
    // that follow each other with no gap.
    task automatic send_sample(input step_t s, input point_t p, input x_t sx, input y_t sy);
        int gap;
        gap = idle_len(send_calm);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid       <= 1'b1;
        samples_ch.step        <= s;
        samples_ch.point_index <= p;
        samples_ch.sample_x    <= sx;
        samples_ch.sample_y    <= sy;
        do
            @(posedge clk);
        while (samples_ch.ready !== 1'b1);
        scoreboard.note_sample(s, p, sx, sy);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted item has come back, then
    // let the pipeline settle
    task automatic drain();
        samples_ch.valid <= 1'b0;
        while (scoreboard.pending() > 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
    endtask

    // Write the shift register while the block is idle; a new value starts
    // a clearing pass, which the next item simply waits out on ready
    task automatic set_shift(input shift_t k);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we    <= 1'b0;
        scoreboard.write_shift(k);
    endtask

    // One phase of random items under shift k.
    //   hot:     hammer a single entry with large Y samples so acc_y wraps
    //   cluster: half the items on a few points of the valid steps
    //   spread:  every field fully random, out-of-range steps included
    task automatic run_random(input shift_t k, input int count, input mix_e mix);
        step_t  hot_step;
        point_t hot_pt;
        step_t  s;
        point_t p;
        x_t     sx;
        y_t     sy;
        int     r;
        set_shift(k);
        hot_step = step_t'($urandom_range(0, NUM_STEPS - 1));
        hot_pt   = point_t'($urandom_range(0, NUM_POINTS - 1));
        for (int i = 0; i < count; i++)
        begin
            r  = $urandom_range(0, 99);
            s  = step_t'($urandom);
            p  = point_t'($urandom);
            sx = x_t'($urandom);
            sy = y_t'($urandom);
            case (mix)
                MIX_HOT:
                    if (r < 85)
                    begin
                        s = hot_step;
                        p = hot_pt;
                        if ($urandom_range(0, 9) != 0)
                            sy = '1;
                    end
                MIX_CLUSTER:
                    if (r < 50)
                    begin
                        s = step_t'($urandom_range(0, NUM_STEPS - 1));
                        p = point_t'($urandom_range(0, 7));
                    end
                default: ;
            endcase
            // Bias X toward its extremes now and then
            r = $urandom_range(0, 19);
            if (r == 0)
                sx = '1;
            else if (r == 1)
                sx = '0;
            send_sample(s, p, sx, sy);
        end
    endtask

    // Receiver: hold ready low for random stalls after reset
    initial
    begin
        int stall;
        averages_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_len(recv_calm);
            if (stall > 0)
            begin
                averages_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            averages_ch.ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Check every accepted averaged item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && averages_ch.valid === 1'b1 && averages_ch.ready === 1'b1)
            scoreboard.check_average(averages_ch.avg_x, averages_ch.avg_y);
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if ((samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1) ||
            (averages_ch.valid === 1'b1 && averages_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        samples_ch.valid       = 1'b0;
        samples_ch.step        = '0;
        samples_ch.point_index = '0;
        samples_ch.sample_x    = '0;
        samples_ch.sample_y    = '0;
        send_calm              = 0;
        recv_calm              = 0;
        idle_cycles            = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Shift is zero out of reset: samples pass straight through
        send_sample(3'd0, 8'd0, 16'h0000, 8'h00);
        send_sample(3'd4, 8'd255, 16'hFFFF, 8'hFF);
        send_sample(3'd7, 8'd128, 16'h1234, 8'h56);

        // Rewrite the same zero: nothing changes
        set_shift(4'd0);
        send_sample(3'd2, 8'd9, 16'hBEEF, 8'hA5);

        // Smallest nonzero shift: accumulate one entry, hit the last entry
        // of the last step, and send steps past the last one (bypass)
        set_shift(4'd1);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd4, 8'd255, 16'hFFFF, 8'hFF);
        send_sample(3'd4, 8'd255, 16'h0000, 8'h00);
        send_sample(3'd5, 8'd10, 16'hAAAA, 8'h55);
        send_sample(3'd6, 8'd0, 16'h5555, 8'hAA);
        send_sample(3'd7, 8'd255, 16'hFFFF, 8'hFF);
        send_sample(3'd2, 8'd17, 16'h8000, 8'h80);
        send_sample(3'd2, 8'd17, 16'h0001, 8'h01);

        // Same shift again: the accumulators are kept
        set_shift(4'd1);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd2, 8'd17, 16'h7FFF, 8'h7F);

        // Largest shift after a change: store starts from zero
        set_shift(4'd15);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd0, 8'd0, 16'hFFFF, 8'hFF);
        send_sample(3'd1, 8'd1, 16'h7FFF, 8'h7F);

        // Random phases across several shift values
        run_random(4'd15, 400, MIX_HOT);
        run_random(4'd0, 80, MIX_SPREAD);
        run_random(shift_t'($urandom_range(2, 14)), 150, MIX_CLUSTER);
        run_random(4'd1, 120, MIX_HOT);
        run_random(4'd8, 100, MIX_SPREAD);

        // Let everything come back, then watch for stray items
        drain();
        repeat (RESULT_LATENCY + 8) @(negedge clk);
        if (scoreboard.failures == 0 && scoreboard.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
